/* src/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// lsf_pkg
// shared constants and controller/datapath interface types for the
// fixed-string line filter
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int LSF_LINE_BYTES  = 64;
  localparam int LSF_PATTERN_MAX = 16;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;
  localparam int LEN_W     = 5;
  localparam int PAT_BYTES = 16;
  localparam int PIDX_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic push;    // take a text byte into store and window
    logic clear;   // end of line: reset line state
    logic rd_en;   // read next stored byte into the read register
    logic sel_nl;  // output byte is the closing newline
  } lsf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic newline;  // input byte is a newline
    logic matched;  // pattern seen in the current line
    logic rd_done;  // all stored bytes have been read
  } lsf_sts_t;

endpackage

/* src/lsf_ctrl.sv */
// ----------------------------------------------------------------------------
// lsf_ctrl
// line filter controller: byte intake, line replay and output handshake
// ----------------------------------------------------------------------------
module lsf_ctrl
  import lsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  output lsf_cmd_t cmd,
  input  lsf_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT,
    S_NL
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;
  logic   last_r,  last_nxt;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    last_nxt   = last_r;
    cmd        = '0;
    cmd.sel_nl = last_r;
    in_ready   = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.newline) begin
            if (sts.matched) begin
              if (sts.rd_done) begin
                state_nxt = S_NL;
                valid_nxt = 1'b1;
                last_nxt  = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end else begin
              cmd.clear = 1'b1;
            end
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT;
        valid_nxt = 1'b1;
        last_nxt  = 1'b0;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (sts.rd_done) begin
            state_nxt = S_NL;
            valid_nxt = 1'b1;
            last_nxt  = 1'b1;
          end else begin
            state_nxt = S_READ;
            valid_nxt = 1'b0;
          end
        end
      end
      S_NL: begin
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
          valid_nxt = 1'b0;
          last_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b0;
        last_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_last  = last_r;

endmodule

/* src/lsf_datapath.sv */
// ----------------------------------------------------------------------------
// lsf_datapath
// pattern registers, line store, recent-byte window and match detection
// ----------------------------------------------------------------------------
module lsf_datapath
  import lsf_pkg::*;
#(
  parameter int LINE_BYTES  = LSF_LINE_BYTES,
  parameter int PATTERN_MAX = LSF_PATTERN_MAX
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output logic [BYTE_W-1:0]    out_byte,
  input  lsf_cmd_t             cmd,
  output lsf_sts_t             sts
);

  localparam int CNT_W  = $clog2(LINE_BYTES);
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam logic [CNT_W-1:0]  STORE_LIMIT = CNT_W'(LINE_BYTES - 1);
  localparam logic [FILL_W-1:0] FILL_MAX    = FILL_W'(PATTERN_MAX);
  localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(PATTERN_MAX);

  // configuration
  logic [CFG_W-1:0] pat_low_r, pat_high_r;
  logic [LEN_W-1:0] pat_len_r;
  logic [BYTE_W-1:0] pat [PAT_BYTES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < PAT_BYTES / 2; i++) begin
      pat[i]                 = pat_low_r[i*BYTE_W +: BYTE_W];
      pat[i + PAT_BYTES / 2] = pat_high_r[i*BYTE_W +: BYTE_W];
    end
  end

  // line state
  logic [BYTE_W-1:0] line_mem [LINE_BYTES];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] win_r   [PATTERN_MAX];
  logic [BYTE_W-1:0] win_nxt [PATTERN_MAX];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              matched_r, matched_nxt;
  logic [FILL_W-1:0] fill_shift;
  logic              hit;
  logic              store_ok;

  assign store_ok = (count_r < STORE_LIMIT);

  // window after taking the input byte, index 0 newest
  always_comb begin
    win_nxt[0] = in_data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    fill_shift = (fill_r == FILL_MAX) ? fill_r : fill_r + FILL_W'(1);
  end

  // substring test against the shifted window
  always_comb begin : match_blk
    logic [LEN_W-1:0] pidx;
    hit  = (pat_len_r != '0) && (pat_len_r <= LEN_MAX) && (LEN_W'(fill_shift) >= pat_len_r);
    pidx = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pidx = pat_len_r - LEN_W'(k) - LEN_W'(1);
      if ((LEN_W'(k) < pat_len_r) && (win_nxt[k] != pat[pidx[PIDX_W-1:0]])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    fill_nxt    = fill_r;
    matched_nxt = matched_r;
    if (cmd.clear) begin
      count_nxt   = '0;
      rd_idx_nxt  = '0;
      fill_nxt    = '0;
      matched_nxt = 1'b0;
    end else if (cmd.push) begin
      if (store_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end
      fill_nxt    = fill_shift;
      matched_nxt = matched_r | hit;
    end else if (cmd.rd_en) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_idx_r  <= '0;
      fill_r    <= '0;
      matched_r <= 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= ZERO_BYTE;
      end
    end else begin
      count_r   <= count_nxt;
      rd_idx_r  <= rd_idx_nxt;
      fill_r    <= fill_nxt;
      matched_r <= matched_nxt;
      if (cmd.clear) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win_r[k] <= ZERO_BYTE;
        end
      end else if (cmd.push) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push && store_ok) begin
      line_mem[count_r] <= in_data_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= line_mem[rd_idx_r];
    end
  end

  assign out_byte    = cmd.sel_nl ? NEWLINE_CODE : rd_data_r;
  assign sts.newline = (in_data_byte == NEWLINE_CODE);
  assign sts.matched = matched_r;
  assign sts.rd_done = (rd_idx_r == count_r);

endmodule

/* src/line_substring_filter.sv */
// ----------------------------------------------------------------------------
// line_substring_filter
// fixed-string line filter: buffers each text line and forwards it, newline
// included, only when the configured pattern occurs somewhere in the line
// ----------------------------------------------------------------------------
// a text byte, or a newline closing a non-matching line, is taken in the
// idle state without output; a matching line is replayed after its newline:
// each stored byte is read (S_READ) and offered (S_EMIT), then the closing
// newline (S_NL); the next byte is read only once the last is taken, as the
// store has a single read port; input is held off while a line is replayed
// reset (rst_n low, synchronous) clears line state and pattern registers
module line_substring_filter
  import lsf_pkg::*;
#(
  parameter int LINE_BYTES  = LSF_LINE_BYTES,   // line store depth, 8 to 64
  parameter int PATTERN_MAX = LSF_PATTERN_MAX   // window depth, 1 to 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // text byte input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data_byte,
  // filtered line output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_last
);

  lsf_cmd_t cmd;  // controller commands
  lsf_sts_t sts;  // datapath status

  // state machine: takes bytes while idle, replays a matched line
  lsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .cmd       (cmd),
    .sts       (sts)
  );

  // store, window and comparators; line bytes past the store's
  // capacity are still matched but dropped from the replay
  lsf_datapath #(
    .LINE_BYTES  (LINE_BYTES),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data_byte (in_data_byte),
    .out_byte     (out_byte),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

/* verif/line_substring_filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_filter_checker
// watches the configuration port and both byte channels of the line filter,
// keeps its own copy of the line and match state, and compares every output
// transaction with the oldest predicted line byte
// ----------------------------------------------------------------------------
module line_substring_filter_checker
  import lsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [BYTE_W-1:0]    out_byte,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   due_count
);

  localparam int STORE_LIMIT = LSF_LINE_BYTES - 1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } line_beat_t;

  line_beat_t              beats_due[$];
  logic [2*CFG_W-1:0]      pattern_bits;
  logic [LEN_W-1:0]        pattern_len;
  logic [BYTE_W-1:0]       held_line [LSF_LINE_BYTES];
  int unsigned             held_count;
  logic [BYTE_W-1:0]       recent [LSF_PATTERN_MAX];  // 0 is the newest byte
  int unsigned             recent_fill;
  logic                    hit_seen;
  int                      errors = 0;

  task automatic clear_line();
    held_count  = 0;
    recent_fill = 0;
    hit_seen    = 1'b0;
    foreach (recent[i]) recent[i] = ZERO_BYTE;
  endtask

  // does the pattern end at the newest byte of the window
  function automatic logic pattern_ends_here();
    int unsigned plen;
    int unsigned k;
    plen = pattern_len;
    if (plen == 0 || plen > LSF_PATTERN_MAX || recent_fill < plen) return 1'b0;
    for (k = 0; k < plen; k++) begin
      if (recent[k] != pattern_bits[(plen - 1 - k)*BYTE_W +: BYTE_W]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic filter_byte(input logic [BYTE_W-1:0] b);
    line_beat_t beat;
    int unsigned k;
    if (b == NEWLINE_CODE) begin
      if (hit_seen) begin
        for (k = 0; k < held_count; k++) begin
          beat.data = held_line[k];
          beat.last = 1'b0;
          beats_due.push_back(beat);
        end
        beat.data = NEWLINE_CODE;
        beat.last = 1'b1;
        beats_due.push_back(beat);
      end
      clear_line();
    end else begin
      // long lines keep matching but stop storing
      if (held_count < STORE_LIMIT) begin
        held_line[held_count] = b;
        held_count++;
      end
      for (k = LSF_PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k - 1];
      recent[0] = b;
      if (recent_fill < LSF_PATTERN_MAX) recent_fill++;
      if (pattern_ends_here()) hit_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    line_beat_t want;
    if (!rst_n) begin
      pattern_bits = '0;
      pattern_len  = '0;
      beats_due.delete();
      clear_line();
    end else begin
      // output first: a byte leaving now belongs to an earlier line
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          $error("unexpected output transaction: out_byte 0x%02h out_last %0b",
                 out_byte, out_last);
          errors++;
        end else begin
          want = beats_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT_LOW:  pattern_bits[CFG_W-1:0]       = cfg_data;
          REG_PAT_HIGH: pattern_bits[2*CFG_W-1:CFG_W] = cfg_data;
          REG_PAT_LEN:  pattern_len                   = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) filter_byte(in_data_byte);
    end
    fail_count <= errors;
    due_count  <= beats_due.size();
  end

endmodule

/* verif/line_substring_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_filter_tb
// drives text lines into the fixed-string line filter under a series of
// pattern settings, with random gaps on the sender and random stalls on the
// receiver; the checker beside the block predicts which lines come back
// ----------------------------------------------------------------------------
module line_substring_filter_tb
  import lsf_pkg::*;
;

  localparam int          ITEM_TARGET       = 330;     // text bytes incl. newlines
  localparam int          LINE_MAX          = 96;
  localparam int unsigned QUIET_CYCLES      = 4;       // settle time before a cfg write
  localparam int unsigned END_CYCLES        = 20;
  localparam int unsigned SINK_HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT       = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // index with no register

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;

  int                   fail_count;
  int                   due_count;

  // copy of the pattern as last written, used to build matching lines
  logic [2*CFG_W-1:0]   pattern_bits = '0;
  logic [LEN_W-1:0]     pattern_len = '0;

  int unsigned          src_gap_pct = 0;     // chance of a gap before a byte
  int unsigned          sink_stall_pct = 25; // chance of a stall per ready cycle
  bit                   sink_hold_req = 1'b0;
  int                   items_sent = 0;
  int unsigned          cycle_count = 0;

  always #5 clk = ~clk;

  line_substring_filter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  line_substring_filter_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .due_count    (due_count)
  );

  // mostly short idles, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // one text byte; valid stays up after the transaction until the next call
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering bytes, wait for every predicted line byte, then let the
  // block finish whatever a non-matching newline left it doing
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // writes the unused index too: that write must be ignored
  task automatic program_pattern(input logic [LEN_W-1:0] plen,
                                 input logic [2*CFG_W-1:0] bits);
    logic [CFG_W-1:0] len_word;
    len_word = {$urandom(), $urandom()};
    len_word[LEN_W-1:0] = plen;   // upper bits carry junk, only the length counts
    pattern_bits = bits;
    pattern_len  = plen;
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= {$urandom(), $urandom()};
    @(posedge clk);
    cfg_index <= REG_PAT_LOW;
    cfg_data  <= bits[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_PAT_HIGH;
    cfg_data  <= bits[2*CFG_W-1:CFG_W];
    @(posedge clk);
    cfg_index <= REG_PAT_LEN;
    cfg_data  <= len_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a line of len text bytes and its newline; with plant set the pattern is
  // copied in at a random spot, narrow draws bytes from a tiny alphabet so
  // that partial and overlapping hits turn up by themselves
  task automatic send_line(input int unsigned len, input bit plant, input bit narrow);
    logic [BYTE_W-1:0] line_buf [LINE_MAX];
    int unsigned       k;
    int unsigned       at;
    bit                usable;
    usable = (pattern_len != 0) && (pattern_len <= LSF_PATTERN_MAX);
    for (k = 0; k < pattern_len && k < LSF_PATTERN_MAX; k++) begin
      if (pattern_bits[k*BYTE_W +: BYTE_W] == NEWLINE_CODE) usable = 1'b0;
    end
    if (plant && usable && len < pattern_len) len = pattern_len;
    for (k = 0; k < len; k++) begin
      if (!narrow) begin
        line_buf[k] = BYTE_W'($urandom_range(0, 255));
      end else if (usable && $urandom_range(0, 3) != 0) begin
        line_buf[k] = pattern_bits[$urandom_range(0, pattern_len - 1)*BYTE_W +: BYTE_W];
      end else begin
        line_buf[k] = BYTE_W'($urandom_range(8'h61, 8'h63));
      end
      // a stray newline would split the line
      if (line_buf[k] == NEWLINE_CODE) line_buf[k] = ~NEWLINE_CODE;
    end
    if (plant && usable) begin
      at = $urandom_range(0, len - pattern_len);
      for (k = 0; k < pattern_len; k++)
        line_buf[at + k] = pattern_bits[k*BYTE_W +: BYTE_W];
    end
    for (k = 0; k < len; k++) send_byte(line_buf[k]);
    send_byte(NEWLINE_CODE);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sink_side
    int unsigned stall_left;
    stall_left = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall_left    = SINK_HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** line_substring_filter: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned       phase;
    int unsigned       phase_end;
    int unsigned       line_no;
    int unsigned       sel;
    int unsigned       len;
    int unsigned       k;
    logic [LEN_W-1:0]  plen;
    logic [2*CFG_W-1:0] bits;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // empty pattern after reset: zero bytes in the window must not count
    send_byte(ZERO_BYTE);
    send_byte(8'hFF);
    send_byte(NEWLINE_CODE);
    wait_idle();

    // single zero byte as pattern: zero is plain text; then an empty line
    program_pattern(5'd1, '0);
    send_byte(ZERO_BYTE);
    send_byte(NEWLINE_CODE);
    send_byte(NEWLINE_CODE);
    wait_idle();

    // "aab" inside "aaab": the hit starts one byte into a false start
    program_pattern(5'd3, {{13{8'hA5}}, 8'h62, 8'h61, 8'h61});
    send_byte(8'h61);
    send_byte(8'h61);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(NEWLINE_CODE);
    wait_idle();

    // full 16-byte pattern of extreme values, the line is exactly the pattern
    bits = 128'hFFFF_0000_4241_FF00_FDFE_0201_7F80_FF00;
    program_pattern(5'd16, bits);
    for (k = 0; k < LSF_PATTERN_MAX; k++) send_byte(bits[k*BYTE_W +: BYTE_W]);
    send_byte(NEWLINE_CODE);

    // ---- random part, one pattern setting per phase ----
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      // the long hold-off phase needs lines that really match
      sel  = (phase == 2) ? 9 : $urandom_range(0, 9);
      bits = {$urandom(), $urandom(), $urandom(), $urandom()};
      for (k = 0; k < 2*CFG_W/BYTE_W; k++) begin
        if (bits[k*BYTE_W +: BYTE_W] == NEWLINE_CODE) bits[k*BYTE_W +: BYTE_W] = 8'hF5;
      end
      case (sel)
        0: plen = 5'd0;                          // empty pattern
        1: plen = LEN_W'($urandom_range(17, 31)); // longer than the window
        2: plen = 5'd16;
        3: begin                                 // newline inside the pattern
          plen = LEN_W'($urandom_range(1, 16));
          bits[$urandom_range(0, plen - 1)*BYTE_W +: BYTE_W] = NEWLINE_CODE;
        end
        default: plen = ($urandom_range(0, 1) != 0) ? LEN_W'($urandom_range(1, 4))
                                                    : LEN_W'($urandom_range(1, 16));
      endcase
      program_pattern(plen, bits);

      // some phases run with no idling at all on one side or the other
      src_gap_pct    = (phase % 3 == 0) ? 0 : $urandom_range(5, 40);
      sink_stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 40);
      if (phase == 2) sink_hold_req = 1'b1;

      phase_end = items_sent + 40;
      line_no   = 0;
      while (items_sent < phase_end) begin
        // mostly short lines, a few long ones, some past the store so they get cut
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 80) : $urandom_range(0, 16);
        send_line(len, (phase == 2) || ($urandom_range(0, 1) != 0),
                  $urandom_range(0, 1) != 0);
        line_no++;
        // sender pause until the output side has caught up
        if (line_no == 1 && (phase == 1 || $urandom_range(0, 2) == 0)) wait_idle();
      end
      phase++;
    end

    // trailing bytes with no newline never come out
    len = $urandom_range(1, 6);
    for (k = 0; k < len; k++) send_byte(8'h61);

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** line_substring_filter: PASSED **");
    end else begin
      $display("** line_substring_filter: FAILED **");
    end
    $finish;
  end

endmodule
